[rtl/core/flrc_pkg.sv]
// ----------------------------------------------------------------------------
// flrc_pkg
// Shared types and constants of the framed link receiver and checker.
// ----------------------------------------------------------------------------
package flrc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;

    localparam int HEAD_BYTES = 12;
    localparam int TAIL_BYTES = 4;

    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    localparam logic [15:0] HEADER_VALUE_RST  = 16'hAAF0;
    localparam logic [15:0] FOOTER_VALUE_RST  = 16'h0000;
    localparam logic [15:0] OWN_ID_RST        = 16'h0000;
    localparam logic [15:0] PEER_ID_RST       = 16'h0000;
    localparam logic [15:0] COMMAND_READY_RST = 16'h0000;
    localparam logic [15:0] COMMAND_STATE_RST = 16'h0001;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ID       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_READY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_STATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd6;

    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FOOTER   = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_COMMAND  = 3'd3;
    localparam logic [2:0] ST_ID       = 3'd4;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_SECOND,
        MODE_HEAD,
        MODE_BODY
    } mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] target_id;
        logic [15:0] source_id;
        logic [15:0] command_code;
        logic [15:0] param_word;
        logic [7:0]  data_len;
    } result_t;

endpackage

[rtl/core/framed_link_receiver_checker.sv]
// ----------------------------------------------------------------------------
// framed_link_receiver_checker
// Hunts for framed packets in a byte stream, passes payload bytes out and
// reports the frame status after the footer word.
// ----------------------------------------------------------------------------
// Each input word is a received byte or a timer tick and is parsed in the cycle
// it is accepted; its result, if any, is registered and presented from the output
// register. One word is accepted per cycle while the skid register is empty. A
// result that finds the output register occupied goes into a one-entry skid
// register; input ready drops only while the skid register is full.
// Configuration writes are taken in every cycle and apply from the next one.
module framed_link_receiver_checker #(
    parameter int MAX_FRAME_BYTES = flrc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [flrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [7:0]                     rx_byte,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kind,
    output logic [7:0]                     payload_byte,
    output logic [2:0]                     status,
    output logic [15:0]                    target_id,
    output logic [15:0]                    source_id,
    output logic [15:0]                    command_code,
    output logic [15:0]                    param_word,
    output logic [7:0]                     data_len
);
    import flrc_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

    logic [15:0] header_value_reg;
    logic [15:0] footer_value_reg;
    logic [15:0] own_id_reg;
    logic [15:0] peer_id_reg;
    logic [15:0] command_ready_reg;
    logic [15:0] command_state_reg;
    logic [15:0] timeout_ticks_reg;

    mode_t       mode_reg, mode_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] checksum_reg, checksum_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] source_reg, source_next;
    logic [15:0] command_reg, command_next;
    logic [15:0] param_reg, param_next;
    logic [15:0] rx_checksum_reg, rx_checksum_next;
    logic [7:0]  footer_low_reg, footer_low_next;
    logic [16:0] idle_reg, idle_next;

    result_t     res;
    logic        res_push;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    result_t     skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        in_fire;
    logic        pop;

    logic [16:0] pos_ext;
    logic [16:0] covered;
    logic [16:0] frame_len;
    logic [16:0] idle_inc;
    logic [IDX_W-1:0] pos_inc;
    logic [IDX_W-1:0] tail_off;
    logic [IDX_W-1:0] head_sel;
    logic [15:0] footer_word;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg  <= HEADER_VALUE_RST;
            footer_value_reg  <= FOOTER_VALUE_RST;
            own_id_reg        <= OWN_ID_RST;
            peer_id_reg       <= PEER_ID_RST;
            command_ready_reg <= COMMAND_READY_RST;
            command_state_reg <= COMMAND_STATE_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_VALUE:  header_value_reg  <= cfg_data;
                CFG_FOOTER_VALUE:  footer_value_reg  <= cfg_data;
                CFG_OWN_ID:        own_id_reg        <= cfg_data;
                CFG_PEER_ID:       peer_id_reg       <= cfg_data;
                CFG_COMMAND_READY: command_ready_reg <= cfg_data;
                CFG_COMMAND_STATE: command_state_reg <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign pos_ext     = 17'(byte_index_reg);
    assign pos_inc     = byte_index_reg + IDX_W'(1);
    assign covered     = 17'(HEAD_BYTES) + {1'b0, length_reg};
    assign tail_off    = IDX_W'(pos_ext - covered);
    assign head_sel    = IDX_W'((byte_index_reg - IDX_W'(2)) >> 1);
    assign idle_inc    = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 17'd1;
    assign footer_word = {rx_byte, footer_low_reg};
    assign frame_len   = {1'b0, length_next} + 17'(HEAD_BYTES + TAIL_BYTES);

    always_comb
    begin
        mode_next        = mode_reg;
        byte_index_next  = byte_index_reg;
        length_next      = length_reg;
        checksum_next    = checksum_reg;
        target_next      = target_reg;
        source_next      = source_reg;
        command_next     = command_reg;
        param_next       = param_reg;
        rx_checksum_next = rx_checksum_reg;
        footer_low_next  = footer_low_reg;
        idle_next        = idle_reg;
        res_push         = 1'b0;

        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.status       = ST_OK;
        res.target_id    = target_reg;
        res.source_id    = source_reg;
        res.command_code = command_reg;
        res.param_word   = param_reg;
        res.data_len     = length_reg[7:0];

        if (in_fire)
        begin
            if (cmd == ITEM_TICK)
            begin
                if (mode_reg != MODE_HUNT)
                begin
                    idle_next = idle_inc;
                    if (idle_inc > {1'b0, timeout_ticks_reg})
                    begin
                        mode_next = MODE_HUNT;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (rx_byte == header_value_reg[7:0])
                        begin
                            mode_next = MODE_SECOND;
                        end
                    end
                    MODE_SECOND:
                    begin
                        if (rx_byte == header_value_reg[15:8])
                        begin
                            target_next      = '0;
                            source_next      = '0;
                            command_next     = '0;
                            param_next       = '0;
                            length_next      = '0;
                            rx_checksum_next = '0;
                            footer_low_next  = '0;
                            checksum_next    = header_value_reg;
                            byte_index_next  = IDX_W'(2);
                            mode_next        = MODE_HEAD;
                        end
                        else
                        begin
                            mode_next = MODE_HUNT;
                        end
                    end
                    MODE_HEAD:
                    begin
                        case (head_sel)
                            IDX_W'(0):
                                if (byte_index_reg[0]) target_next[15:8] = rx_byte;
                                else                   target_next[7:0]  = rx_byte;
                            IDX_W'(1):
                                if (byte_index_reg[0]) source_next[15:8] = rx_byte;
                                else                   source_next[7:0]  = rx_byte;
                            IDX_W'(2):
                                if (byte_index_reg[0]) command_next[15:8] = rx_byte;
                                else                   command_next[7:0]  = rx_byte;
                            IDX_W'(3):
                                if (byte_index_reg[0]) param_next[15:8] = rx_byte;
                                else                   param_next[7:0]  = rx_byte;
                            default:
                                if (byte_index_reg[0]) length_next[15:8] = rx_byte;
                                else                   length_next[7:0]  = rx_byte;
                        endcase
                        if (byte_index_reg[0])
                        begin
                            checksum_next = checksum_reg ^ {rx_byte, 8'h00};
                        end
                        else
                        begin
                            checksum_next = checksum_reg ^ {8'h00, rx_byte};
                        end
                        byte_index_next = pos_inc;
                        if (pos_ext + 17'd1 >= 17'(HEAD_BYTES))
                        begin
                            if (frame_len >= 17'(MAX_FRAME_BYTES))
                            begin
                                mode_next = MODE_HUNT;
                            end
                            else
                            begin
                                mode_next = MODE_BODY;
                            end
                        end
                    end
                    default:
                    begin
                        byte_index_next = pos_inc;
                        if (pos_ext < covered)
                        begin
                            if (byte_index_reg[0])
                            begin
                                checksum_next = checksum_reg ^ {rx_byte, 8'h00};
                            end
                            else if (pos_ext + 17'd1 < covered)
                            begin
                                checksum_next = checksum_reg ^ {8'h00, rx_byte};
                            end
                            res_push = 1'b1;
                        end
                        else
                        begin
                            case (tail_off[1:0])
                                2'd0: rx_checksum_next = {8'h00, rx_byte};
                                2'd1: rx_checksum_next = {rx_byte, rx_checksum_reg[7:0]};
                                2'd2: footer_low_next  = rx_byte;
                                default:
                                begin
                                    res.kind         = KIND_REPORT;
                                    res.payload_byte = 8'h00;
                                    if (footer_word != footer_value_reg)
                                        res.status = ST_FOOTER;
                                    else if (~checksum_reg != rx_checksum_reg)
                                        res.status = ST_CHECKSUM;
                                    else if (command_reg != command_ready_reg &&
                                             command_reg != command_state_reg)
                                        res.status = ST_COMMAND;
                                    else if (target_reg != own_id_reg ||
                                             source_reg != peer_id_reg)
                                        res.status = ST_ID;
                                    else
                                        res.status = ST_OK;
                                    res_push  = 1'b1;
                                    mode_next = MODE_HUNT;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = res_push;
            end
            else
            begin
                out_next        = res;
                out_valid_next  = res_push;
            end
        end
        else if (res_push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_HUNT;
            byte_index_reg  <= '0;
            length_reg      <= '0;
            checksum_reg    <= '0;
            target_reg      <= '0;
            source_reg      <= '0;
            command_reg     <= '0;
            param_reg       <= '0;
            rx_checksum_reg <= '0;
            footer_low_reg  <= '0;
            idle_reg        <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            byte_index_reg  <= byte_index_next;
            length_reg      <= length_next;
            checksum_reg    <= checksum_next;
            target_reg      <= target_next;
            source_reg      <= source_next;
            command_reg     <= command_next;
            param_reg       <= param_next;
            rx_checksum_reg <= rx_checksum_next;
            footer_low_reg  <= footer_low_next;
            idle_reg        <= idle_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign payload_byte = out_reg.payload_byte;
    assign status       = out_reg.status;
    assign target_id    = out_reg.target_id;
    assign source_id    = out_reg.source_id;
    assign command_code = out_reg.command_code;
    assign param_word   = out_reg.param_word;
    assign data_len     = out_reg.data_len;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without output word");

    a_report_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_REPORT) |=> mode_reg == MODE_HUNT)
        else $error("parser not hunting after frame report");

    a_payload_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_PAYLOAD) |-> mode_reg == MODE_BODY)
        else $error("payload word produced outside frame body");

    a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.kind == KIND_REPORT && out_reg.payload_byte == 8'h00
                            && out_reg.status <= ST_ID) ||
                           (out_reg.kind == KIND_PAYLOAD && out_reg.status == ST_OK)))
        else $error("inconsistent result word");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_BODY |-> pos_ext < covered + 17'(TAIL_BYTES))
        else $error("byte index past frame end");
`endif

endmodule
